// ===== hdl/bounded_doubly_linked_list_engine_top_assert.svh =====
// Assertion macros for the linked list engine.
`ifndef BOUNDED_DOUBLY_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BDLL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BDLL_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define BDLL_ASSERT(label, clk, rst_n, prop, msg)
`define BDLL_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== hdl/bdll_pkg.sv =====
// ----------------------------------------------------------------------------
// bdll_pkg
// Opcodes, status codes and the controller to datapath command and status.
// ----------------------------------------------------------------------------
package bdll_pkg;
	localparam logic [3:0] OP_PREPEND   = 4'd0;
	localparam logic [3:0] OP_APPEND    = 4'd1;
	localparam logic [3:0] OP_SEARCH    = 4'd2;
	localparam logic [3:0] OP_UPDATE    = 4'd3;
	localparam logic [3:0] OP_DEL_FIRST = 4'd4;
	localparam logic [3:0] OP_DEL_LAST  = 4'd5;
	localparam logic [3:0] OP_DEL_VALUE = 4'd6;
	localparam logic [3:0] OP_DUMP_FWD  = 4'd7;
	localparam logic [3:0] OP_DUMP_BACK = 4'd8;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_INSERT,
		CMD_STEP,
		CMD_UPDATE,
		CMD_UNLINK
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic    back;
	} cmd_t;

	typedef struct packed {
		logic        full;
		logic        empty;
		logic        cur_ok;
		logic        nxt_ok;
		logic        match;
		logic        steps_done;
		logic [31:0] cur_value;
	} stat_t;
endpackage

// ===== hdl/bdll_datapath.sv =====
// ----------------------------------------------------------------------------
// bdll_datapath
// Node, link and free-slot stores with the walking pointer and a step count.
// ----------------------------------------------------------------------------
module bdll_datapath #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bdll_pkg::cmd_t      cmd,
	input  logic signed [31:0]  value,
	input  logic signed [31:0]  new_value,
	output bdll_pkg::stat_t     stat
);
	import bdll_pkg::*;

	localparam int SW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [SW-1:0] NIL = SW'(CAPACITY);

	logic [31:0]   node_value [CAPACITY];
	logic [SW-1:0] next_link [CAPACITY];
	logic [SW-1:0] prev_link [CAPACITY];
	logic [CAPACITY-1:0] free_q;
	logic [SW-1:0] head_q, tail_q, cur_q, steps_q;
	logic [SW-1:0] free_slot, cur_nxt, cur_prv, cur_fwd;
	logic          cur_ok, p_ok, n_ok;

	always_comb begin
		free_slot = NIL;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				free_slot = SW'(i);
			end
		end
	end

	assign cur_ok  = cur_q < NIL;
	assign cur_nxt = cur_ok ? next_link[cur_q[IW-1:0]] : NIL;
	assign cur_prv = cur_ok ? prev_link[cur_q[IW-1:0]] : NIL;
	assign cur_fwd = cmd.back ? cur_prv : cur_nxt;
	assign p_ok    = cur_prv < NIL;
	assign n_ok    = cur_nxt < NIL;

	assign stat.full       = !(free_slot < NIL);
	assign stat.empty      = !(head_q < NIL);
	assign stat.cur_ok     = cur_ok;
	assign stat.nxt_ok     = cur_fwd < NIL;
	assign stat.cur_value  = cur_ok ? node_value[cur_q[IW-1:0]] : 32'd0;
	assign stat.match      = cur_ok && (node_value[cur_q[IW-1:0]] == value);
	assign stat.steps_done = (steps_q + SW'(1)) >= NIL;

	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_INSERT: begin
				if (!stat.full) begin
					node_value[free_slot[IW-1:0]] <= value;
					if (!cmd.back) begin
						prev_link[free_slot[IW-1:0]] <= NIL;
						next_link[free_slot[IW-1:0]] <= head_q;
						if (head_q < NIL) begin
							prev_link[head_q[IW-1:0]] <= free_slot;
						end
					end else begin
						next_link[free_slot[IW-1:0]] <= NIL;
						prev_link[free_slot[IW-1:0]] <= tail_q;
						if (tail_q < NIL) begin
							next_link[tail_q[IW-1:0]] <= free_slot;
						end
					end
				end
			end
			CMD_UPDATE: begin
				if (cur_ok) begin
					node_value[cur_q[IW-1:0]] <= new_value;
				end
			end
			CMD_UNLINK: begin
				if (p_ok) begin
					next_link[cur_prv[IW-1:0]] <= cur_nxt;
				end
				if (n_ok) begin
					prev_link[cur_nxt[IW-1:0]] <= cur_prv;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= '1;
			head_q  <= NIL;
			tail_q  <= NIL;
			cur_q   <= NIL;
			steps_q <= '0;
		end else begin
			case (cmd.op)
				CMD_LOAD: begin
					cur_q   <= cmd.back ? tail_q : head_q;
					steps_q <= '0;
				end
				CMD_STEP: begin
					cur_q   <= cur_fwd;
					steps_q <= steps_q + SW'(1);
				end
				CMD_INSERT: begin
					if (!stat.full) begin
						free_q[free_slot[IW-1:0]] <= 1'b0;
						if (!cmd.back) begin
							head_q <= free_slot;
							if (!(head_q < NIL)) begin
								tail_q <= free_slot;
							end
						end else begin
							tail_q <= free_slot;
							if (!(tail_q < NIL)) begin
								head_q <= free_slot;
							end
						end
					end
				end
				CMD_UNLINK: begin
					if (cur_ok) begin
						free_q[cur_q[IW-1:0]] <= 1'b1;
						if (!p_ok) begin
							head_q <= cur_nxt;
						end
						if (!n_ok) begin
							tail_q <= cur_prv;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end
endmodule

// ===== hdl/bdll_controller.sv =====
// ----------------------------------------------------------------------------
// bdll_controller
// Sequences each request and drives the result register.
// ----------------------------------------------------------------------------
`include "bounded_doubly_linked_list_engine_top_assert.svh"
module bdll_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  logic [3:0]         opcode,
	output bdll_pkg::cmd_t     cmd,
	input  bdll_pkg::stat_t    stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] data,
	output logic               last
);
	import bdll_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_FIND, S_DUMP, S_OUT} state_t;
	state_t      state_q;
	logic [3:0]  op_q;
	logic        out_free;

	assign ready    = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd.op   = CMD_NONE;
		cmd.back = (op_q == OP_APPEND) || (op_q == OP_DUMP_BACK) || (op_q == OP_DEL_LAST);
		case (state_q)
			S_IDLE: begin
				if (valid) begin
					cmd.op   = CMD_LOAD;
					cmd.back = (opcode == OP_DUMP_BACK) || (opcode == OP_DEL_LAST);
				end
			end
			S_DISPATCH: begin
				if (out_free && ((op_q == OP_PREPEND) || (op_q == OP_APPEND))) begin
					cmd.op = CMD_INSERT;
				end else if (out_free && !stat.empty &&
						((op_q == OP_DEL_FIRST) || (op_q == OP_DEL_LAST))) begin
					cmd.op = CMD_UNLINK;
				end
			end
			S_FIND: begin
				if (out_free) begin
					if (stat.match) begin
						cmd.op = (op_q == OP_UPDATE) ? CMD_UPDATE :
							(op_q == OP_DEL_VALUE) ? CMD_UNLINK : CMD_NONE;
					end else if (stat.cur_ok && !stat.steps_done) begin
						cmd.op = CMD_STEP;
					end
				end
			end
			S_DUMP: begin
				if (out_free && !stat.steps_done) begin
					cmd.op = CMD_STEP;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= '0;
			out_valid <= 1'b0;
			status    <= ST_OK;
			data      <= '0;
			last      <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (valid) begin
						op_q    <= opcode;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (out_free) begin
						data <= '0;
						last <= 1'b1;
						state_q <= S_IDLE;
						case (op_q)
							OP_PREPEND, OP_APPEND: begin
								status    <= stat.full ? ST_FULL : ST_OK;
								out_valid <= 1'b1;
							end
							OP_SEARCH, OP_UPDATE: begin
								state_q <= S_FIND;
							end
							OP_DEL_FIRST, OP_DEL_LAST: begin
								status    <= stat.empty ? ST_EMPTY : ST_OK;
								out_valid <= 1'b1;
							end
							OP_DEL_VALUE: begin
								if (stat.empty) begin
									status    <= ST_EMPTY;
									out_valid <= 1'b1;
								end else begin
									state_q <= S_FIND;
								end
							end
							OP_DUMP_FWD, OP_DUMP_BACK: begin
								if (stat.empty) begin
									status    <= ST_EMPTY;
									out_valid <= 1'b1;
								end else begin
									state_q <= S_DUMP;
								end
							end
							default: begin
								status    <= ST_OK;
								out_valid <= 1'b1;
							end
						endcase
					end
				end
				S_FIND: begin
					if (out_free) begin
						if (stat.match) begin
							status    <= ST_OK;
							data      <= '0;
							last      <= 1'b1;
							out_valid <= 1'b1;
							state_q   <= S_IDLE;
						end else if (!stat.cur_ok || stat.steps_done) begin
							status    <= ST_NOT_FOUND;
							data      <= '0;
							last      <= 1'b1;
							out_valid <= 1'b1;
							state_q   <= S_IDLE;
						end
					end
				end
				S_DUMP: begin
					if (out_free) begin
						status    <= ST_OK;
						data      <= stat.cur_value;
						last      <= !stat.nxt_ok || stat.steps_done;
						out_valid <= 1'b1;
						if (!stat.nxt_ok || stat.steps_done) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BDLL_ASSERT(a_ready_idle, clk, arst_n, ready |-> (state_q == S_IDLE), "ready outside idle")
	`BDLL_ASSERT_NEXT(a_accept_leaves, clk, arst_n, valid && ready, (state_q == S_DISPATCH), "accept did not dispatch")
	`BDLL_ASSERT(a_dump_ok, clk, arst_n, (out_valid && !last) |-> (status == ST_OK), "partial dump result not ok")
	`BDLL_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(data) && $stable(last), "result dropped while stalled")
endmodule

// ===== hdl/bounded_doubly_linked_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// bounded_doubly_linked_list_engine_top
// Doubly linked list of signed 32-bit values in CAPACITY slots.
// ----------------------------------------------------------------------------
// Requests enter on valid/ready with opcode, value and new_value; results leave
// on out_valid/out_ready with status, data and last. One request is handled at
// a time: ready is high only while the engine is idle.
// Inserts, deletes by position and unused opcodes give their result from the
// dispatch state. Search, update and delete by value walk the links one node
// per cycle while the result register is free, and examine at most CAPACITY
// nodes. A dump issues one result per node, one per cycle while the receiver
// takes the results, and the last result carries last set.
// Reset empties the list and clears the result register; no clearing pass runs.
// A stalled receiver holds the result register and pauses the walk in place
// until the result is taken.
// ----------------------------------------------------------------------------
module bounded_doubly_linked_list_engine_top #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               ready,
	input  logic [3:0]         opcode,
	input  logic signed [31:0] value,
	input  logic signed [31:0] new_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic signed [31:0] data,
	output logic               last
);
	import bdll_pkg::*;

	cmd_t        cmd;
	stat_t       stat;
	logic signed [31:0] value_q, new_value_q;

	always_ff @(posedge clk) begin
		if (valid && ready) begin
			value_q     <= value;
			new_value_q <= new_value;
		end
	end

	bdll_controller u_ctrl (
		.clk, .arst_n, .valid, .ready, .opcode, .cmd, .stat,
		.out_valid, .out_ready, .status, .data, .last
	);

	bdll_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk, .arst_n, .cmd, .value(value_q), .new_value(new_value_q), .stat
	);
endmodule
